FILE: rtl/trpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpg_pkg
// Shared types and constants of the trapezoidal ramp profile generator.
// ----------------------------------------------------------------------------
package trpg_pkg;

    localparam logic [63:0] CAP62  = 64'h4000_0000_0000_0000;
    localparam logic [30:0] MASK31 = 31'h7FFF_FFFF;

    localparam logic [1:0] CFG_MAX_VEL = 2'd0;
    localparam logic [1:0] CFG_ACCEL   = 2'd1;
    localparam logic [1:0] CFG_PERIOD  = 2'd2;
    localparam logic [1:0] CFG_MIN_VEL = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MAGACC, ST_SQRT, ST_CHECK, ST_TBDIV, ST_TBCEIL, ST_TEDIV,
        ST_TECEIL, ST_ASTEPS, ST_CSTEPS, ST_TIME, ST_SQ, ST_ACCSQ, ST_VT,
        ST_VTV, ST_VV, ST_VVDIV, ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_MAGACC, OP_SQRT, OP_TBDIV, OP_TBCEIL, OP_TEDIV, OP_TECEIL,
        OP_ASTEPS, OP_CSTEPS, OP_TIME, OP_SQ, OP_ACCSQ, OP_VT, OP_VTV,
        OP_VV, OP_VVDIV
    } op_t;

    typedef enum logic [1:0] {
        PH_ACCEL, PH_CRUISE, PH_DECEL
    } phase_t;

    typedef enum logic [1:0] {
        RES_ZERO, RES_START, RES_TICK
    } res_t;

    typedef struct packed {
        logic start;
        op_t  op;
        logic capture;
        logic out_load;
        res_t res;
    } cmd_t;

    typedef struct packed {
        logic   done;
        logic   cdur;
        logic   active;
        logic   reject;
        phase_t phase;
    } sts_t;

endpackage

FILE: rtl/trapezoid_ramp_profile_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_ramp_profile_generator_unit
// Trapezoidal velocity profile generator, signed fixed point, start and tick.
// ----------------------------------------------------------------------------
// one word in flight; s_ready is high only while idle
// start word: a product, a root, then divider passes; two more divider passes when the
//   duration is computed, none when the word is rejected
// tick word: products only in accel and decel, one divider pass in cruise, none while idle
// a stalled result word holds the next word in its finish state until the result is taken
// synchronous active-low reset returns the default registers and drops any move
module trapezoid_ramp_profile_generator_unit #(
    parameter int STEP_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [31:0] s_distance,
    input  logic [30:0]        s_duration,
    input  logic               s_compute_duration,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_ok,
    output logic signed [31:0] m_position,
    output logic               m_last,
    output logic [30:0]        m_ramp_time,
    output logic [30:0]        m_total_time,
    output logic [30:0]        m_cruise_velocity
);
    import trpg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    trpg_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_func), .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    trpg_dp #(.STEP_BITS(STEP_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_distance(s_distance), .s_duration(s_duration),
        .s_compute_duration(s_compute_duration), .m_ok(m_ok),
        .m_position(m_position), .m_last(m_last), .m_ramp_time(m_ramp_time),
        .m_total_time(m_total_time), .m_cruise_velocity(m_cruise_velocity),
        .cmd(cmd), .sts(sts)
    );

endmodule

FILE: rtl/trpg_mulq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpg_mulq
// 64x64 multiplier from four 32x32 partial products, with fixed-point result.
// ----------------------------------------------------------------------------
module trpg_mulq #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod,
    output logic [63:0]  q
);
    import trpg_pkg::*;

    logic         busy_reg;
    logic [2:0]   k_reg;
    logic         pp_vld_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   ppsh_reg;
    logic [127:0] acc_reg;
    logic [63:0]  a_reg, b_reg;
    logic         done_reg;
    logic [31:0]  a_sel, b_sel;
    logic [127:0] pp_shifted;
    logic [127:0] sh;

    assign a_sel = k_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_sel = k_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        unique case (ppsh_reg)
            2'd0:    pp_shifted = {64'b0, pp_reg};
            2'd1:    pp_shifted = {32'b0, pp_reg, 32'b0};
            2'd2:    pp_shifted = {pp_reg, 64'b0};
            default: pp_shifted = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
            k_reg      <= '0;
        end else if (start) begin
            a_reg      <= a;
            b_reg      <= b;
            busy_reg   <= 1'b1;
            k_reg      <= '0;
            pp_vld_reg <= 1'b0;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            if (k_reg != 3'd4) begin
                pp_reg     <= a_sel * b_sel;
                ppsh_reg   <= {1'b0, k_reg[1]} + {1'b0, k_reg[0]};
                pp_vld_reg <= 1'b1;
                k_reg      <= k_reg + 3'd1;
            end else begin
                pp_vld_reg <= 1'b0;
            end
            if (pp_vld_reg) begin
                acc_reg <= acc_reg + pp_shifted;
            end
            if (k_reg == 3'd4 && pp_vld_reg) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign sh   = acc_reg >> FRAC_BITS;
    assign q    = (|sh[127:64] || sh[63:0] > CAP62) ? CAP62 : sh[63:0];
    assign prod = acc_reg;
    assign done = done_reg;

endmodule

FILE: rtl/trpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpg_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module trpg_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] n,
    input  logic [31:0] d,
    output logic        done,
    output logic [63:0] q,
    output logic [31:0] r
);
    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] nq_reg;
    logic [31:0] d_reg;
    logic        done_reg;
    logic [32:0] cand, diff;
    logic        ge;

    assign cand = {rem_reg, nq_reg[63]};
    assign diff = cand - {1'b0, d_reg};
    assign ge   = cand >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            nq_reg   <= n;
            d_reg    <= d;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : cand[31:0];
            nq_reg  <= {nq_reg[62:0], ge};
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign q    = nq_reg;
    assign r    = rem_reg;
    assign done = done_reg;

endmodule

FILE: rtl/trpg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpg_sqrt
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module trpg_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] x,
    output logic        done,
    output logic [31:0] root
);
    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [63:0] x_reg;
    logic        done_reg;
    logic [34:0] cand, trial;
    logic        ge;

    assign cand  = {rem_reg[32:0], x_reg[63:62]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = cand >= trial;

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            x_reg    <= x;
        end else if (busy_reg) begin
            rem_reg  <= ge ? cand - trial : cand;
            root_reg <= {root_reg[30:0], ge};
            x_reg    <= {x_reg[61:0], 2'b00};
            cnt_reg  <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

FILE: rtl/trpg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpg_ctrl
// Sequencer: walks a start or tick word through the shared arithmetic units.
// ----------------------------------------------------------------------------
module trpg_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_func,
    output logic            m_valid,
    input  logic            m_ready,
    input  trpg_pkg::sts_t  sts,
    output trpg_pkg::cmd_t  cmd
);
    import trpg_pkg::*;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;
    logic   issued_reg, issued_next;
    logic   m_valid_reg, m_valid_next;
    logic   unit_state;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            res_reg     <= RES_ZERO;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        res_next    = res_reg;
        issued_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_func) begin
                        state_next = ST_MAGACC;
                    end else if (sts.active) begin
                        state_next = ST_TIME;
                    end else begin
                        state_next = ST_FINISH;
                        res_next   = RES_ZERO;
                    end
                end
            end
            ST_CHECK: begin
                if (sts.reject) begin
                    state_next = ST_FINISH;
                    res_next   = RES_ZERO;
                end else begin
                    state_next = ST_TBDIV;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                issued_next = !sts.done;
                if (sts.done) begin
                    unique case (state_reg)
                        ST_MAGACC: state_next = ST_SQRT;
                        ST_SQRT:   state_next = ST_CHECK;
                        ST_TBDIV:  state_next = ST_TBCEIL;
                        ST_TBCEIL: state_next = sts.cdur ? ST_TEDIV : ST_ASTEPS;
                        ST_TEDIV:  state_next = ST_TECEIL;
                        ST_TECEIL: state_next = ST_ASTEPS;
                        ST_ASTEPS: state_next = ST_CSTEPS;
                        ST_CSTEPS: begin
                            state_next = ST_FINISH;
                            res_next   = RES_START;
                        end
                        ST_TIME: begin
                            unique case (sts.phase)
                                PH_ACCEL:  state_next = ST_SQ;
                                PH_CRUISE: state_next = ST_VT;
                                default:   state_next = ST_VTV;
                            endcase
                        end
                        ST_SQ:    state_next = ST_ACCSQ;
                        ST_VT:    state_next = ST_VV;
                        ST_VV:    state_next = ST_VVDIV;
                        ST_VTV:   state_next = ST_SQ;
                        default: begin
                            state_next = ST_FINISH;
                            res_next   = RES_TICK;
                        end
                    endcase
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd.op     = OP_NONE;
        unit_state = 1'b1;
        unique case (state_reg)
            ST_MAGACC: cmd.op = OP_MAGACC;
            ST_SQRT:   cmd.op = OP_SQRT;
            ST_TBDIV:  cmd.op = OP_TBDIV;
            ST_TBCEIL: cmd.op = OP_TBCEIL;
            ST_TEDIV:  cmd.op = OP_TEDIV;
            ST_TECEIL: cmd.op = OP_TECEIL;
            ST_ASTEPS: cmd.op = OP_ASTEPS;
            ST_CSTEPS: cmd.op = OP_CSTEPS;
            ST_TIME:   cmd.op = OP_TIME;
            ST_SQ:     cmd.op = OP_SQ;
            ST_ACCSQ:  cmd.op = OP_ACCSQ;
            ST_VT:     cmd.op = OP_VT;
            ST_VTV:    cmd.op = OP_VTV;
            ST_VV:     cmd.op = OP_VV;
            ST_VVDIV:  cmd.op = OP_VVDIV;
            default:   unit_state = 1'b0;
        endcase
        cmd.start    = unit_state && !issued_reg;
        cmd.capture  = (state_reg == ST_IDLE) && s_valid;
        cmd.out_load = (state_reg == ST_FINISH) && out_free;
        cmd.res      = res_reg;
        s_ready      = (state_reg == ST_IDLE);
        m_valid      = m_valid_reg;
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

endmodule

FILE: rtl/trpg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpg_dp
// Datapath: config registers, move state, operand selection and result words.
// ----------------------------------------------------------------------------
module trpg_dp #(
    parameter int STEP_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_wdata,
    input  logic signed [31:0] s_distance,
    input  logic [30:0]        s_duration,
    input  logic               s_compute_duration,
    output logic               m_ok,
    output logic signed [31:0] m_position,
    output logic               m_last,
    output logic [30:0]        m_ramp_time,
    output logic [30:0]        m_total_time,
    output logic [30:0]        m_cruise_velocity,
    input  trpg_pkg::cmd_t     cmd,
    output trpg_pkg::sts_t     sts
);
    import trpg_pkg::*;

    localparam int          SW       = STEP_BITS + 2;
    localparam logic [63:0] STEP_MAX = (64'd1 << STEP_BITS) - 64'd1;

    logic [30:0] maxv_reg, accc_reg, ipoc_reg, minv_reg;
    logic [30:0] acc_eff, ipo_eff;
    logic [31:0] dist_reg;
    logic [30:0] dur_reg;
    logic        cdur_reg;
    logic [31:0] mag;
    logic [30:0] vel_reg, tb_reg, te_reg;
    logic [63:0] a_reg, b_reg, t_reg;
    logic signed [63:0] term_reg;
    logic [SW-1:0] step_reg, i_val, last_sum;
    logic [STEP_BITS-1:0] as_reg, cs_reg, ds_reg;
    logic        active_reg, neg_reg;
    logic        ok_reg, last_reg;
    logic [31:0] pos_reg;
    logic [30:0] ramp_reg, total_reg, cv_reg;

    logic [63:0]  mul_a, mul_b, div_n, mul_q;
    logic [127:0] mul_prod;
    logic [31:0]  div_d, div_r, root;
    logic [63:0]  div_q, sqrt_x;
    logic         mul_start, div_start, sqrt_start;
    logic         mul_done, div_done, sqrt_done, done;

    phase_t       phase;
    logic signed [32:0] tv;
    logic [31:0]  tvm;
    logic signed [64:0] dt;
    logic [63:0]  dtm;
    logic signed [33:0] xcs;
    logic [63:0]  up;
    logic [STEP_BITS-1:0] qsat;
    logic signed [63:0] half, raw, sgn;
    logic [31:0]  pos;
    logic         is_last;

    assign acc_eff = (accc_reg == '0) ? 31'd1 : accc_reg;
    assign ipo_eff = (ipoc_reg == '0) ? 31'd1 : ipoc_reg;
    assign mag     = dist_reg[31] ? 32'(32'd0 - dist_reg) : dist_reg;

    assign i_val    = step_reg + SW'(1);
    assign last_sum = SW'(as_reg) + SW'(cs_reg) + SW'(ds_reg) + SW'(1);
    assign is_last  = (i_val == last_sum);

    always_comb begin
        if (i_val <= SW'(as_reg)) begin
            phase = PH_ACCEL;
        end else if (i_val <= SW'(as_reg) + SW'(cs_reg)) begin
            phase = PH_CRUISE;
        end else begin
            phase = PH_DECEL;
        end
    end

    assign tv  = $signed({2'b00, te_reg}) - $signed({2'b00, tb_reg});
    assign tvm = tv[32] ? 32'(-tv) : tv[31:0];
    assign dt  = $signed({34'd0, te_reg}) - $signed({1'b0, t_reg});
    assign dtm = dt[64] ? 64'(-dt) : dt[63:0];
    assign xcs = $signed({3'b000, te_reg}) - $signed({2'b00, tb_reg, 1'b0});

    // round up to a whole period, clamped to 31 bits
    assign up   = a_reg + ((div_r != '0) ? {33'd0, ipo_eff - div_r[30:0]} : 64'd0);
    assign qsat = (div_q > STEP_MAX) ? {STEP_BITS{1'b1}} : div_q[STEP_BITS-1:0];

    always_comb begin
        mul_a = '0; mul_b = '0; div_n = '0; div_d = {1'b0, ipo_eff}; sqrt_x = a_reg;
        mul_start = 1'b0; div_start = 1'b0; sqrt_start = 1'b0;
        unique case (cmd.op)
            OP_MAGACC: begin
                mul_a = {32'd0, mag}; mul_b = {33'd0, acc_eff}; mul_start = cmd.start;
            end
            OP_SQRT:   sqrt_start = cmd.start;
            OP_TBDIV: begin
                div_n = {33'd0, vel_reg} << FRAC_BITS; div_d = {1'b0, acc_eff};
                div_start = cmd.start;
            end
            OP_TBCEIL, OP_TECEIL: begin
                div_n = a_reg; div_start = cmd.start;
            end
            OP_TEDIV: begin
                div_n = {32'd0, mag} << FRAC_BITS; div_d = {1'b0, vel_reg};
                div_start = cmd.start;
            end
            OP_ASTEPS: begin
                div_n = {33'd0, tb_reg}; div_start = cmd.start;
            end
            OP_CSTEPS: begin
                div_n = xcs[33] ? 64'd0 : {30'd0, xcs}; div_start = cmd.start;
            end
            OP_TIME: begin
                mul_a = {33'd0, ipo_eff}; mul_b = 64'(i_val); mul_start = cmd.start;
            end
            OP_SQ: begin
                mul_a = (phase == PH_ACCEL) ? t_reg : dtm;
                mul_b = mul_a; mul_start = cmd.start;
            end
            OP_ACCSQ: begin
                mul_a = {33'd0, acc_eff}; mul_b = a_reg; mul_start = cmd.start;
            end
            OP_VT: begin
                mul_a = {33'd0, vel_reg}; mul_b = t_reg; mul_start = cmd.start;
            end
            OP_VTV: begin
                mul_a = {33'd0, vel_reg}; mul_b = {32'd0, tvm}; mul_start = cmd.start;
            end
            OP_VV: begin
                mul_a = {33'd0, vel_reg}; mul_b = {33'd0, vel_reg}; mul_start = cmd.start;
            end
            OP_VVDIV: begin
                div_n = a_reg; div_d = {1'b0, acc_eff}; div_start = cmd.start;
            end
            default: ;
        endcase
    end

    trpg_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .prod(mul_prod), .q(mul_q)
    );

    trpg_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .n(div_n), .d(div_d),
        .done(div_done), .q(div_q), .r(div_r)
    );

    trpg_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start), .x(sqrt_x),
        .done(sqrt_done), .root(root)
    );

    assign done = mul_done || div_done || sqrt_done;

    // tick position: accel ramp, or cruise/decel term minus the half-square part
    assign half = $signed({1'b0, b_reg[63:1]});
    assign raw  = (phase == PH_ACCEL) ? half : term_reg - half;
    assign sgn  = neg_reg ? -raw : raw;
    always_comb begin
        if (sgn > 64'sd2147483647) begin
            pos = 32'h7FFF_FFFF;
        end else if (sgn < -64'sd2147483648) begin
            pos = 32'h8000_0000;
        end else begin
            pos = sgn[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            maxv_reg   <= 31'd65536;
            accc_reg   <= 31'd65536;
            ipoc_reg   <= 31'd655;
            minv_reg   <= 31'd66;
            active_reg <= 1'b0;
            neg_reg    <= 1'b0;
            vel_reg    <= '0;
            tb_reg     <= '0;
            te_reg     <= '0;
            step_reg   <= '0;
            as_reg     <= '0;
            cs_reg     <= '0;
            ds_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MAX_VEL: maxv_reg <= cfg_wdata;
                    CFG_ACCEL:   accc_reg <= cfg_wdata;
                    CFG_PERIOD:  ipoc_reg <= cfg_wdata;
                    CFG_MIN_VEL: minv_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (done) begin
                unique case (cmd.op)
                    OP_MAGACC: a_reg <= mul_prod[63:0];
                    OP_SQRT: vel_reg <= ({1'b0, maxv_reg} > root) ? root[30:0] : maxv_reg;
                    OP_TBDIV:  a_reg <= div_q;
                    OP_TBCEIL: begin
                        tb_reg <= (|up[63:31]) ? MASK31 : up[30:0];
                        if (!cdur_reg) begin
                            te_reg <= dur_reg;
                        end
                    end
                    OP_TEDIV:  a_reg <= div_q + {33'd0, tb_reg};
                    OP_TECEIL: te_reg <= (|up[63:31]) ? MASK31 : up[30:0];
                    OP_ASTEPS: begin
                        as_reg <= qsat;
                        ds_reg <= qsat;
                    end
                    OP_CSTEPS: cs_reg <= qsat;
                    OP_TIME: t_reg <= (|mul_prod[127:64] || mul_prod[63:0] > CAP62) ?
                                      CAP62 : mul_prod[63:0];
                    OP_SQ:    a_reg <= mul_q;
                    OP_ACCSQ: b_reg <= mul_q;
                    OP_VT:    term_reg <= $signed(mul_q);
                    OP_VTV:   term_reg <= tv[32] ? -$signed(mul_q) : $signed(mul_q);
                    OP_VV:    a_reg <= mul_prod[63:0];
                    OP_VVDIV: b_reg <= div_q;
                    default: ;
                endcase
            end
            if (cmd.out_load) begin
                unique case (cmd.res)
                    RES_START: begin
                        active_reg <= 1'b1;
                        neg_reg    <= dist_reg[31];
                        step_reg   <= '0;
                    end
                    RES_TICK: begin
                        step_reg <= i_val;
                        if (is_last) begin
                            active_reg <= 1'b0;
                        end
                    end
                    default: active_reg <= 1'b0;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            dist_reg <= s_distance;
            dur_reg  <= s_duration;
            cdur_reg <= s_compute_duration;
        end
        if (cmd.out_load) begin
            ok_reg    <= (cmd.res != RES_ZERO);
            pos_reg   <= (cmd.res == RES_TICK) ? pos : 32'd0;
            last_reg  <= (cmd.res == RES_TICK) && is_last;
            ramp_reg  <= (cmd.res == RES_START) ? tb_reg : 31'd0;
            total_reg <= (cmd.res == RES_START) ? te_reg : 31'd0;
            cv_reg    <= (cmd.res == RES_START) ? vel_reg : 31'd0;
        end
    end

    assign m_ok              = ok_reg;
    assign m_position        = pos_reg;
    assign m_last            = last_reg;
    assign m_ramp_time       = ramp_reg;
    assign m_total_time      = total_reg;
    assign m_cruise_velocity = cv_reg;

    assign sts.done   = done;
    assign sts.cdur   = cdur_reg;
    assign sts.active = active_reg;
    assign sts.reject = (vel_reg <= minv_reg);
    assign sts.phase  = phase;

endmodule

FILE: rtl/trpg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trpg_checker
// Port-level checks of the profile generator, bound to the top level.
// ----------------------------------------------------------------------------
module trpg_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_ok,
    input logic signed [31:0] m_position,
    input logic               m_last,
    input logic [30:0]        m_total_time,
    input logic [30:0]        m_cruise_velocity
);
    // a held result keeps its position and last flag
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_last))
        else $error("result changed while stalled");

    // one word in flight: no accept right after an accept
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted back to back");

    // rejected words carry nothing
    a_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_position == 32'sd0 && !m_last && m_total_time == 31'd0)
        else $error("rejected result not zero");

    // start report has no position and is never last
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cruise_velocity != 31'd0 |-> m_ok && !m_last && m_position == 32'sd0)
        else $error("start result malformed");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_ok)
        else $error("last point without ok");

endmodule

bind trapezoid_ramp_profile_generator_unit trpg_checker u_trpg_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_ok(m_ok), .m_position(m_position),
    .m_last(m_last), .m_total_time(m_total_time), .m_cruise_velocity(m_cruise_velocity)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the trapezoid ramp profile generator. Start and tick words go
// through the valid/ready channels and every result word is checked against
// a fixed-point profile model. The run covers several register settings,
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import trpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1780;

    typedef struct {
        logic        ok;
        logic [31:0] position;
        logic        last;
        logic [30:0] ramp_time;
        logic [30:0] total_time;
        logic [30:0] cruise_velocity;
    } profile_res_t;

    typedef struct {
        logic        func;
        logic [31:0] distance;
        logic [30:0] duration;
        logic        cdur;
        logic        typed;
        logic        ok;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = CFG_MAX_VEL;
    logic [30:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_func = 1'b0;
    logic signed [31:0] s_distance = '0;
    logic [30:0]        s_duration = '0;
    logic               s_compute_duration = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_ok;
    logic signed [31:0] m_position;
    logic               m_last;
    logic [30:0]        m_ramp_time;
    logic [30:0]        m_total_time;
    logic [30:0]        m_cruise_velocity;

    // profile model state
    logic [63:0] vmax_q = 64'd65536, accel_q = 64'd65536, period_q = 64'd655;
    logic [63:0] vmin_q = 64'd66;
    logic        mv_active = 1'b0, mv_neg = 1'b0;
    logic [63:0] mv_vel = '0, mv_tb = '0, mv_te = '0;
    longint      mv_tv = 0;
    logic [63:0] mv_index = '0, mv_a = '0, mv_c = '0, mv_d = '0;

    profile_res_t expected_words[$];
    int           n_fail = 0;
    int           burst_left = 0;
    logic         hold_long = 1'b0;
    int           stall_cnt = 0;
    int           idle_cycles = 0;

    always #5 aclk = ~aclk;

    trapezoid_ramp_profile_generator_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_distance(s_distance), .s_duration(s_duration),
        .s_compute_duration(s_compute_duration),
        .m_valid(m_valid), .m_ready(m_ready), .m_ok(m_ok),
        .m_position(m_position), .m_last(m_last), .m_ramp_time(m_ramp_time),
        .m_total_time(m_total_time), .m_cruise_velocity(m_cruise_velocity)
    );

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        logic [63:0]  r;
        p = {64'd0, a} * {64'd0, b};
        if (p[127:80] != 0) return CAP62;
        r = p[79:16];
        return (r > CAP62) ? CAP62 : r;
    endfunction

    function automatic logic [63:0] ceil_to(input logic [63:0] x, input logic [63:0] m);
        logic [63:0] q;
        q = x / m + ((x % m) != 0 ? 64'd1 : 64'd0);
        if (q > CAP62 / m) return CAP62;
        return q * m;
    endfunction

    function automatic logic [63:0] clip_steps(input logic [63:0] x);
        return (x > 64'd65535) ? 64'd65535 : x;
    endfunction

    function automatic profile_res_t predict_profile(input logic func, input logic [31:0] dist_in,
                                                     input logic [30:0] dur, input logic cdur);
        profile_res_t r;
        logic [63:0]  acc, ipo, mag, vel, tb, te, i, t, tvm, dtm;
        longint       tv, x, pos, dt, term;
        r = '{1'b0, 32'd0, 1'b0, 31'd0, 31'd0, 31'd0};
        acc = (accel_q != 0) ? accel_q : 64'd1;
        ipo = (period_q != 0) ? period_q : 64'd1;
        if (func == 1'b0) begin
            mag = dist_in[31] ? (64'h1_0000_0000 - {32'd0, dist_in}) : {32'd0, dist_in};
            vel = floor_sqrt(mag * acc);
            if (vmax_q < vel) vel = vmax_q;
            if (vel <= vmin_q) begin
                mv_active = 1'b0;
                return r;
            end
            tb = ceil_to((vel << 16) / acc, ipo);
            if (tb > 64'h7FFF_FFFF) tb = 64'h7FFF_FFFF;
            if (cdur) begin
                te = ceil_to((mag << 16) / vel + tb, ipo);
                if (te > 64'h7FFF_FFFF) te = 64'h7FFF_FFFF;
            end else begin
                te = {33'd0, dur};
            end
            tv = longint'(te) - longint'(tb);
            mv_a = clip_steps(tb / ipo);
            x = tv - longint'(tb);
            mv_c = (x <= 0) ? 64'd0 : clip_steps(64'(x) / ipo);
            x = longint'(te) - tv;
            mv_d = (x <= 0) ? 64'd0 : clip_steps(64'(x) / ipo);
            mv_neg = dist_in[31];
            mv_vel = vel; mv_tb = tb; mv_te = te; mv_tv = tv;
            mv_index = 0; mv_active = 1'b1;
            r.ok = 1'b1; r.ramp_time = tb[30:0]; r.total_time = te[30:0];
            r.cruise_velocity = vel[30:0];
            return r;
        end
        if (!mv_active) return r;
        i = mv_index + 1;
        t = (ipo > CAP62 / i) ? CAP62 : ipo * i;
        if (i <= mv_a) begin
            pos = longint'(fx_mul(acc, fx_mul(t, t)) >> 1);
        end else if (i <= mv_a + mv_c) begin
            pos = longint'(fx_mul(mv_vel, t)) - longint'(((mv_vel * mv_vel) / acc) >> 1);
        end else begin
            dt = longint'(mv_te) - longint'(t);
            tvm = (mv_tv < 0) ? 64'(-mv_tv) : 64'(mv_tv);
            dtm = (dt < 0) ? 64'(-dt) : 64'(dt);
            term = longint'(fx_mul(mv_vel, tvm));
            if (mv_tv < 0) term = -term;
            pos = term - longint'(fx_mul(acc, fx_mul(dtm, dtm)) >> 1);
        end
        if (mv_neg) pos = -pos;
        if (pos > 64'sh7FFF_FFFF) pos = 64'sh7FFF_FFFF;
        if (pos < -64'sh8000_0000) pos = -64'sh8000_0000;
        r.last = (i == mv_a + mv_c + mv_d + 1);
        mv_index = i;
        if (r.last) mv_active = 1'b0;
        r.ok = 1'b1;
        r.position = pos[31:0];
        return r;
    endfunction

    // called right after a rising edge; leaves s_valid high on return
    task automatic send_word(input logic func, input logic [31:0] dist_in,
                             input logic [30:0] dur, input logic cdur, input logic typed,
                             input logic typed_ok);
        profile_res_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_func <= func;
        s_distance <= dist_in;
        s_duration <= dur;
        s_compute_duration <= cdur;
        r = predict_profile(func, dist_in, dur, cdur);
        // typed rows are all-zero results (idle tick, rejected start)
        if (typed) r = '{typed_ok, 32'd0, 1'b0, 31'd0, 31'd0, 31'd0};
        expected_words.insert(expected_words.size(), r);
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [30:0] vmax, input logic [30:0] acc,
                              input logic [30:0] per, input logic [30:0] vmin);
        cfg_we <= 1'b1; cfg_index <= CFG_MAX_VEL; cfg_wdata <= vmax;
        @(posedge aclk);
        cfg_index <= CFG_ACCEL; cfg_wdata <= acc;
        @(posedge aclk);
        cfg_index <= CFG_PERIOD; cfg_wdata <= per;
        @(posedge aclk);
        cfg_index <= CFG_MIN_VEL; cfg_wdata <= vmin;
        @(posedge aclk);
        cfg_we <= 1'b0;
        vmax_q = {33'd0, vmax}; accel_q = {33'd0, acc};
        period_q = {33'd0, per}; vmin_q = {33'd0, vmin};
    endtask

    function automatic logic [31:0] pick_distance();
        logic [31:0] d;
        case ($urandom_range(0, 9))
            0: d = $urandom;
            1: d = 32'd0;
            2: d = $urandom_range(1, 64);
            default: d = $urandom_range(1, 32'h0020_0000);
        endcase
        if ($urandom_range(0, 1)) d = -d;
        return d;
    endfunction

    // receiver: stall pattern steps through four modes over time; one long hold on request
    always @(posedge aclk) begin
        if (hold_long && stall_cnt < 3000) begin
            stall_cnt <= stall_cnt + 1;
            m_ready <= 1'b0;
        end else begin
            case (($time / 640) % 4)
                0: m_ready <= 1'b1;
                1: m_ready <= ~m_ready;
                2: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        profile_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                n_fail++;
            end else begin
                e = expected_words.pop_front();
                if (m_ok !== e.ok) begin
                    $error("ok: expected %0d, got %0d", e.ok, m_ok); n_fail++;
                end
                if (m_position !== e.position) begin
                    $error("position: expected %0d, got %0d", $signed(e.position), m_position);
                    n_fail++;
                end
                if (m_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_last); n_fail++;
                end
                if (m_ramp_time !== e.ramp_time) begin
                    $error("ramp_time: expected %0d, got %0d", e.ramp_time, m_ramp_time);
                    n_fail++;
                end
                if (m_total_time !== e.total_time) begin
                    $error("total_time: expected %0d, got %0d", e.total_time, m_total_time);
                    n_fail++;
                end
                if (m_cruise_velocity !== e.cruise_velocity) begin
                    $error("cruise_velocity: expected %0d, got %0d", e.cruise_velocity,
                           m_cruise_velocity);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("trapezoid_ramp_profile_generator_unit: mismatch");
            $finish;
        end
    end

    initial begin
        dir_row_t    rows[$];
        logic [31:0] d;
        int          nticks;
        int          sent;
        int          ph;

        rows = '{
            '{1'b1, 32'd0,          31'd0,          1'b1, 1'b1, 1'b0}, // tick while idle
            '{1'b0, 32'd0,          31'd0,          1'b1, 1'b1, 1'b0}, // zero distance
            '{1'b0, 32'h8000_0000,  31'd0,          1'b1, 1'b0, 1'b0},
            '{1'b1, 32'd0,          31'd0,          1'b0, 1'b0, 1'b0},
            '{1'b1, 32'hFFFF_FFFF,  31'h7FFF_FFFF,  1'b1, 1'b0, 1'b0},
            '{1'b0, 32'h7FFF_FFFF,  31'h7FFF_FFFF,  1'b0, 1'b0, 1'b0},
            '{1'b1, 32'd0,          31'd0,          1'b0, 1'b0, 1'b0},
            '{1'b0, 32'd65536,      31'd0,          1'b0, 1'b0, 1'b0}, // duration under ramp
            '{1'b1, 32'd0,          31'd0,          1'b0, 1'b0, 1'b0},
            '{1'b1, 32'd0,          31'd0,          1'b0, 1'b0, 1'b0},
            '{1'b1, 32'd0,          31'd0,          1'b0, 1'b0, 1'b0},
            '{1'b0, 32'hFFFF_FFFF,  31'd1000,       1'b0, 1'b0, 1'b0},
            '{1'b1, 32'd0,          31'd0,          1'b0, 1'b0, 1'b0},
            '{1'b0, 32'd0,          31'd0,          1'b1, 1'b1, 1'b0}, // below min velocity
            '{1'b1, 32'd0,          31'd0,          1'b0, 1'b1, 1'b0}, // dropped move
            '{1'b0, 32'hFFFF_0000,  31'd0,          1'b1, 1'b0, 1'b0},
            '{1'b1, 32'd0,          31'd0,          1'b0, 1'b0, 1'b0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[k])
            send_word(rows[k].func, rows[k].distance, rows[k].duration, rows[k].cdur,
                      rows[k].typed, rows[k].ok);
        wait_drained();

        sent = 0;
        ph = 0;
        while (sent < N_RANDOM) begin
            case (ph)
                0: write_regs(31'd262144, 31'd65536, 31'd6554, 31'd66);
                1: write_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
                2: write_regs(31'd0, 31'd1, 31'd1, 31'd0);
                3: write_regs(31'h7FFF_FFFF, 31'd0, 31'd0, 31'h7FFF_FFFF);
                4: write_regs(31'h7FFF_FFFF, 31'd1, 31'd65536, 31'd0);
                default: begin
                    if ($urandom_range(0, 4) == 0)
                        write_regs(31'($urandom), 31'($urandom), 31'($urandom),
                                   31'($urandom_range(0, 255)));
                    else
                        write_regs(31'($urandom_range(65536, 32'h0040_0000)),
                                   31'($urandom_range(1, 32'h0040_0000)),
                                   31'($urandom_range(655, 65536)),
                                   31'($urandom_range(0, 4096)));
                end
            endcase
            @(posedge aclk);
            repeat (25) begin
                if (sent < N_RANDOM) begin
                    d = pick_distance();
                    if ($urandom_range(0, 7) == 0) begin
                        // noise: a stray tick
                        send_word(1'b1, $urandom, 31'($urandom), 1'($urandom_range(0, 1)),
                                  1'b0, 1'b0);
                        sent++;
                    end
                    send_word(1'b0, d, 31'($urandom), ($urandom_range(0, 3) != 0), 1'b0, 1'b0);
                    sent++;
                    nticks = $urandom_range(1, 40);
                    while (mv_active && nticks > 0) begin
                        send_word(1'b1, $urandom, 31'($urandom), 1'($urandom_range(0, 1)),
                                  1'b0, 1'b0);
                        nticks--;
                        sent++;
                    end
                    if (ph == 1 && sent > 0 && !hold_long) hold_long = 1'b1;
                end
            end
            wait_drained();
            ph++;
        end

        wait_drained();
        if (n_fail == 0) begin
            $display("trapezoid_ramp_profile_generator_unit: match");
        end else begin
            $display("trapezoid_ramp_profile_generator_unit: mismatch");
        end
        $finish;
    end

endmodule
